// ===== rtl/pid_with_filtered_derivative_core_macros.svh =====
// Assertion macros shared by the PID core RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PID_WITH_FILTERED_DERIVATIVE_CORE_MACROS_SVH
`define PID_WITH_FILTERED_DERIVATIVE_CORE_MACROS_SVH

// Plain property check.
`define PFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// When cond holds, expr must hold in the following cycle.
`define PFD_ASSERT_NEXT(name, cond, expr, msg) \
  `PFD_ASSERT(name, (cond) |=> (expr), msg)

`endif

// ===== rtl/pfd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PID core: widths, register codes, sequencer steps, FIR
// coefficients and the control struct of the shared multiply-accumulate unit.
package pfd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int IO_W           = 32;
  localparam int GAIN_W         = 24;
  localparam int BLEND_W        = 17;
  localparam int LIM_W          = 31;
  localparam int CFG_W          = 31;
  localparam int CFG_IDX_W      = 3;
  localparam int FIR_TAPS       = 12;
  localparam int TAP_IDX_W      = $clog2(FIR_TAPS);
  localparam int TAP_GAIN_W     = 16;

  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;
  localparam logic [LIM_W-1:0]   LIM_RESET = 31'h7FFF_FFFF;

  // Symmetric low-pass coefficients, Q0.16.
  localparam logic [TAP_GAIN_W-1:0] TAP_GAIN [FIR_TAPS] = '{
    16'd746,   16'd1519, 16'd3639, 16'd6548, 16'd9318, 16'd11000,
    16'd11000, 16'd9318, 16'd6548, 16'd3639, 16'd1519, 16'd746
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN   = 3'd0,
    CFG_KI_GAIN   = 3'd1,
    CFG_KD_GAIN   = 3'd2,
    CFG_INT_WIN   = 3'd3,
    CFG_INT_MAX   = 3'd4,
    CFG_BLEND     = 3'd5,
    CFG_OUT_MAX   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHG,
    S_INTEG,
    S_CLAMP,
    S_MAC,
    S_SUM,
    S_DONE
  } pfd_state_e;

  // Multiply-accumulate schedule. Each product takes a high and a low pass.
  localparam int ST_FIR_FIRST_I = 12;
  localparam int ST_FIR_LAST_I  = ST_FIR_FIRST_I + 2 * FIR_TAPS - 1;
  localparam int ST_FIR_DONE_I  = ST_FIR_LAST_I + 2;
  localparam int STEP_W         = $clog2(ST_FIR_DONE_I + 1);

  localparam logic [STEP_W-1:0] ST_P_HI      = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_P_LO      = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_I_HI      = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_I_LO      = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_D_HI      = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_D_LO      = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_B0_HI     = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_B0_LO     = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_B1_HI     = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_B1_LO     = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_BLEND     = STEP_W'(11);
  localparam logic [STEP_W-1:0] ST_FIR_FIRST = STEP_W'(ST_FIR_FIRST_I);
  localparam logic [STEP_W-1:0] ST_FIR_LAST  = STEP_W'(ST_FIR_LAST_I);
  localparam logic [STEP_W-1:0] ST_FIR_DONE  = STEP_W'(ST_FIR_DONE_I);

  typedef struct packed {
    logic issue;
    logic lo;
    logic clr;
  } mac_ctrl_t;

  function automatic int acc_width(input int dw);
    return ((dw > 32) ? dw : 32) + 10;
  endfunction

  function automatic int mul_a_width(input int dw);
    return ((dw - 16) > 17) ? (dw - 16) : 17;
  endfunction

  function automatic logic [TAP_GAIN_W-1:0] tap_gain(input logic [TAP_IDX_W-1:0] idx);
    if (int'(idx) < FIR_TAPS) begin
      return TAP_GAIN[idx];
    end
    return '0;
  endfunction

endpackage

// ===== rtl/pfd_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one registered product, one accumulator.
// Depends on pfd_pkg and the assertion macro header.
`include "pid_with_filtered_derivative_core_macros.svh"

module pfd_mac #(
  parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  pfd_pkg::mac_ctrl_t                                ctrl_i,
  input  logic signed [DATA_WIDTH-1:0]                      v_i,
  input  logic [pfd_pkg::GAIN_W-1:0]                        k_i,
  output logic signed [pfd_pkg::acc_width(DATA_WIDTH)-1:0]  acc_o
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = pfd_pkg::acc_width(DATA_WIDTH);
  localparam int MA = pfd_pkg::mul_a_width(DATA_WIDTH);
  localparam int KW = pfd_pkg::GAIN_W;
  localparam int PW = MA + KW + 1;

  logic signed [MA+16:0]  v_ext;
  logic signed [MA-1:0]   v_hi;
  logic signed [MA-1:0]   v_lo;
  logic signed [MA-1:0]   op_a;
  logic signed [KW:0]     op_b;
  logic signed [PW-1:0]   prod_d;
  logic signed [PW-1:0]   prod_q;
  logic                   pv_q;
  logic                   plo_q;
  logic                   pclr_q;
  logic signed [AW-1:0]   add_val;
  logic signed [AW-1:0]   acc_q;

  // The value splits into a signed upper part (floor of v / 2^16) and the
  // unsigned low 16 bits, so floor(v * k / 2^16) is exact in two passes.
  assign v_ext  = {{(MA + 17 - DW){v_i[DW-1]}}, v_i};
  assign v_hi   = MA'(v_ext >>> 16);
  assign v_lo   = {{(MA - 16){1'b0}}, v_i[15:0]};
  assign op_a   = ctrl_i.lo ? v_lo : v_hi;
  assign op_b   = {1'b0, k_i};
  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      plo_q  <= 1'b0;
      pclr_q <= 1'b0;
    end else begin
      pv_q   <= ctrl_i.issue;
      plo_q  <= ctrl_i.lo;
      pclr_q <= ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign add_val = plo_q ? AW'(prod_q >>> 16) : AW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      acc_q <= (pclr_q ? '0 : acc_q) + add_val;
    end
  end

  assign acc_o = acc_q;

  `PFD_ASSERT(a_lo_after_hi, ctrl_i.issue && ctrl_i.lo |-> $past(ctrl_i.issue && !ctrl_i.lo), "low pass issued without its high pass")
  `PFD_ASSERT(a_clr_on_hi, ctrl_i.clr |-> ctrl_i.issue && !ctrl_i.lo, "accumulator clear not on a high pass")

endmodule

// ===== rtl/pfd_taps.sv =====
`timescale 1ns / 1ps
// Derivative FIR delay line with a clear, a shift-in and one read port.
// Depends on pfd_pkg.
module pfd_taps #(
  parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clr_i,
  input  logic                              shift_i,
  input  logic signed [DATA_WIDTH-1:0]      din_i,
  input  logic [pfd_pkg::TAP_IDX_W-1:0]     idx_i,
  output logic signed [DATA_WIDTH-1:0]      dout_o
);

  localparam int NT = pfd_pkg::FIR_TAPS;

  logic signed [DATA_WIDTH-1:0] taps_q [NT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NT; i++) begin
        taps_q[i] <= '0;
      end
    end else if (clr_i) begin
      for (int i = 0; i < NT; i++) begin
        taps_q[i] <= '0;
      end
    end else if (shift_i) begin
      taps_q[0] <= din_i;
      for (int i = 1; i < NT; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
    end
  end

  assign dout_o = (int'(idx_i) < NT) ? taps_q[idx_i] : '0;

endmodule

// ===== rtl/pid_with_filtered_derivative_core.sv =====
`timescale 1ns / 1ps
// PID controller core: request sequencer, controller state and output register.
// Depends on pfd_pkg, pfd_mac, pfd_taps and the assertion macro header.
//
// Usage. Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i
// while the core is idle; indexes 0..6 select kp, ki, kd, integral window,
// integral limit, derivative blend and output limit, and other indexes are
// ignored. Requests enter on in_valid_i / in_stall_o and are taken at a clock
// edge with in_valid_i high and in_stall_o low. A clear request zeroes last
// error, integral, previous derivative and every FIR tap in its accept cycle
// and produces no result. A compute request produces one drive_o result on
// out_valid_o / out_stall_i.
// Schedule. All products run through one multiply-accumulate unit, two passes
// per product: kp, ki and kd, then the two blend products, then twelve FIR
// products when fir_enable_i is set. An accepted compute request steps through
// S_CHG, S_INTEG, S_CLAMP, S_MAC, S_SUM and S_DONE, and its result is then
// registered in the output register. The core does not take a request while a
// computation is running.
// Stalls. A finished result waits in the output register while out_stall_i is
// high; a request taken meanwhile computes and then holds in its last state
// until that register frees. Reset clears the controller state, sets the
// configuration to its defaults and empties the output register.
`include "pid_with_filtered_derivative_core_macros.svh"

module pid_with_filtered_derivative_core #(
  parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfd_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [pfd_pkg::IO_W-1:0]   setpoint_i,
  input  logic signed [pfd_pkg::IO_W-1:0]   measurement_i,
  input  logic                              integral_mode_i,
  input  logic                              fir_enable_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pfd_pkg::IO_W-1:0]   drive_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int AW  = pfd_pkg::acc_width(DATA_WIDTH);
  localparam int IOW = pfd_pkg::IO_W;
  localparam int KW  = pfd_pkg::GAIN_W;
  localparam int BW  = pfd_pkg::BLEND_W;
  localparam int LW  = pfd_pkg::LIM_W;
  localparam int SW  = pfd_pkg::STEP_W;
  localparam int TW  = pfd_pkg::TAP_IDX_W;
  localparam int GW  = pfd_pkg::TAP_GAIN_W;

  localparam logic signed [AW-1:0] DMAX = {{(AW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [AW-1:0] DMIN = ~DMAX;

  // Limit a wide value to the signed data range.
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [AW-1:0] v);
    if (v > DMAX) begin
      return DW'(DMAX);
    end
    if (v < DMIN) begin
      return DW'(DMIN);
    end
    return DW'(v);
  endfunction

  // Symmetric clamp to +-lim.
  function automatic logic signed [AW-1:0] clamp_sym(input logic signed [AW-1:0] v,
                                                     input logic [LW-1:0] lim);
    logic signed [AW-1:0] l;
    l = $signed({{(AW - LW){1'b0}}, lim});
    if (v > l) begin
      return l;
    end
    if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

  // Configuration registers.
  logic [KW-1:0] kp_q, ki_q, kd_q;
  logic [LW-1:0] win_q, imax_q, omax_q;
  logic [BW-1:0] blend_q;

  // Sequencer.
  pfd_pkg::pfd_state_e state_q, state_d;
  logic [SW-1:0]       step_q, step_d;

  // Controller state, cleared by reset and by a clear request.
  logic signed [DW-1:0] last_err_q, isum_q, prev_d_q;

  // Per-request working registers.
  logic signed [DW-1:0] err_q, chg_q, p_q, i_q, raw_q, d_q;
  logic signed [AW-1:0] sum_q;
  logic                 mode_q, fir_q, inwin_q;
  logic signed [IOW-1:0] drive_q;
  logic                 out_valid_q;

  // Sequencer outputs.
  pfd_pkg::mac_ctrl_t   mac_ctrl;
  logic signed [DW-1:0] mac_v;
  logic [KW-1:0]        mac_k;
  logic signed [AW-1:0] mac_acc;
  logic                 col_p, col_i, col_raw, col_d;
  logic                 tap_shift, load_out;
  logic [TW-1:0]        tap_idx;
  logic signed [DW-1:0] tap_rd;
  logic signed [DW-1:0] acc_sat;

  logic                 in_acc;
  logic                 clr_req;
  logic [BW-1:0]        blend_w, blend_nw;
  logic signed [AW-1:0] err_w;
  logic signed [AW-1:0] win_w;

  assign in_stall_o = (state_q != pfd_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign clr_req    = in_acc && req_type_i;

  // Blend weights above one act as one.
  assign blend_w  = (blend_q > pfd_pkg::BLEND_ONE) ? pfd_pkg::BLEND_ONE : blend_q;
  assign blend_nw = pfd_pkg::BLEND_ONE - blend_w;

  assign acc_sat = sat_dw(mac_acc);
  assign tap_idx = TW'((step_q - pfd_pkg::ST_FIR_FIRST) >> 1);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      win_q   <= pfd_pkg::LIM_RESET;
      imax_q  <= pfd_pkg::LIM_RESET;
      blend_q <= pfd_pkg::BLEND_ONE;
      omax_q  <= pfd_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pfd_pkg::CFG_KP_GAIN: kp_q    <= cfg_data_i[KW-1:0];
        pfd_pkg::CFG_KI_GAIN: ki_q    <= cfg_data_i[KW-1:0];
        pfd_pkg::CFG_KD_GAIN: kd_q    <= cfg_data_i[KW-1:0];
        pfd_pkg::CFG_INT_WIN: win_q   <= cfg_data_i[LW-1:0];
        pfd_pkg::CFG_INT_MAX: imax_q  <= cfg_data_i[LW-1:0];
        pfd_pkg::CFG_BLEND:   blend_q <= cfg_data_i[BW-1:0];
        pfd_pkg::CFG_OUT_MAX: omax_q  <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfd_pkg::S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and sequencer strobes. In the multiply-accumulate phase a
  // group's sum is ready only once its last pass has gone through the product
  // register and the accumulator, which is why each collect strobe trails its group.
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    mac_ctrl  = '0;
    mac_v     = err_q;
    mac_k     = '0;
    col_p     = 1'b0;
    col_i     = 1'b0;
    col_raw   = 1'b0;
    col_d     = 1'b0;
    tap_shift = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      pfd_pkg::S_IDLE: begin
        if (in_valid_i && !req_type_i) begin
          state_d = pfd_pkg::S_CHG;
        end
      end
      pfd_pkg::S_CHG: begin
        state_d = pfd_pkg::S_INTEG;
      end
      pfd_pkg::S_INTEG: begin
        state_d = pfd_pkg::S_CLAMP;
      end
      pfd_pkg::S_CLAMP: begin
        state_d = pfd_pkg::S_MAC;
        step_d  = '0;
      end
      pfd_pkg::S_MAC: begin
        step_d = step_q + SW'(1);
        case (step_q) inside
          pfd_pkg::ST_P_HI, pfd_pkg::ST_P_LO: begin
            mac_ctrl.issue = 1'b1;
            mac_v          = err_q;
            mac_k          = kp_q;
          end
          pfd_pkg::ST_I_HI, pfd_pkg::ST_I_LO: begin
            mac_ctrl.issue = 1'b1;
            mac_v          = isum_q;
            mac_k          = ki_q;
          end
          pfd_pkg::ST_D_HI, pfd_pkg::ST_D_LO: begin
            mac_ctrl.issue = 1'b1;
            mac_v          = chg_q;
            mac_k          = kd_q;
          end
          pfd_pkg::ST_B0_HI, pfd_pkg::ST_B0_LO: begin
            mac_ctrl.issue = 1'b1;
            mac_v          = prev_d_q;
            mac_k          = {{(KW - BW){1'b0}}, blend_nw};
          end
          pfd_pkg::ST_B1_HI, pfd_pkg::ST_B1_LO: begin
            mac_ctrl.issue = 1'b1;
            mac_v          = raw_q;
            mac_k          = {{(KW - BW){1'b0}}, blend_w};
          end
          [pfd_pkg::ST_FIR_FIRST:pfd_pkg::ST_FIR_LAST]: begin
            mac_ctrl.issue = 1'b1;
            mac_v          = tap_rd;
            mac_k          = {{(KW - GW){1'b0}}, pfd_pkg::tap_gain(tap_idx)};
          end
          default: ;
        endcase
        mac_ctrl.lo  = mac_ctrl.issue && step_q[0];
        mac_ctrl.clr = mac_ctrl.issue &&
                       (step_q == pfd_pkg::ST_P_HI || step_q == pfd_pkg::ST_I_HI ||
                        step_q == pfd_pkg::ST_D_HI || step_q == pfd_pkg::ST_B0_HI ||
                        step_q == pfd_pkg::ST_FIR_FIRST);
        case (step_q)
          pfd_pkg::ST_I_LO:  col_p   = 1'b1;
          pfd_pkg::ST_D_LO:  col_i   = 1'b1;
          pfd_pkg::ST_B0_LO: col_raw = 1'b1;
          pfd_pkg::ST_BLEND: begin
            if (fir_q) begin
              tap_shift = 1'b1;
            end else begin
              col_d   = 1'b1;
              state_d = pfd_pkg::S_SUM;
            end
          end
          pfd_pkg::ST_FIR_DONE: begin
            col_d   = 1'b1;
            state_d = pfd_pkg::S_SUM;
          end
          default: ;
        endcase
      end
      pfd_pkg::S_SUM: begin
        state_d = pfd_pkg::S_DONE;
      end
      pfd_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = pfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pfd_pkg::S_IDLE;
      end
    endcase
  end

  assign err_w = AW'(err_q);
  assign win_w = $signed({{(AW - LW){1'b0}}, win_q});

  // Controller state. The integral is accumulated first and clamped in the next
  // cycle, in S_CLAMP, on every compute request, whether it accumulated or not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      isum_q     <= '0;
      prev_d_q   <= '0;
    end else if (clr_req) begin
      last_err_q <= '0;
      isum_q     <= '0;
      prev_d_q   <= '0;
    end else begin
      if (state_q == pfd_pkg::S_INTEG && (!mode_q || inwin_q)) begin
        isum_q <= sat_dw(AW'(isum_q) + err_w);
      end
      if (state_q == pfd_pkg::S_CLAMP) begin
        isum_q     <= DW'(clamp_sym(AW'(isum_q), imax_q));
        last_err_q <= err_q;
      end
      if (col_d) begin
        prev_d_q <= acc_sat;
      end
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q  <= sat_dw(AW'(setpoint_i) - AW'(measurement_i));
      mode_q <= integral_mode_i;
      fir_q  <= fir_enable_i;
    end
    if (state_q == pfd_pkg::S_CHG) begin
      chg_q   <= sat_dw(err_w - AW'(last_err_q));
      inwin_q <= (err_w <= win_w) && (err_w >= -win_w);
    end
    if (col_p) begin
      p_q <= acc_sat;
    end
    if (col_i) begin
      i_q <= acc_sat;
    end
    if (col_raw) begin
      raw_q <= acc_sat;
    end
    if (col_d) begin
      d_q <= acc_sat;
    end
    if (state_q == pfd_pkg::S_SUM) begin
      sum_q <= AW'(p_q) + AW'(i_q) + AW'(d_q);
    end
    if (load_out) begin
      drive_q <= IOW'(clamp_sym(sum_q, omax_q));
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  pfd_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .v_i    (mac_v),
    .k_i    (mac_k),
    .acc_o  (mac_acc)
  );

  pfd_taps #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_taps (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr_req),
    .shift_i (tap_shift),
    .din_i   (acc_sat),
    .idx_i   (tap_idx),
    .dout_o  (tap_rd)
  );

  `PFD_ASSERT_NEXT(a_clear_zeroes, clr_req, isum_q == '0 && prev_d_q == '0 && last_err_q == '0, "clear request left controller state")
  `PFD_ASSERT(a_step_bound, state_q == pfd_pkg::S_MAC |-> step_q <= pfd_pkg::ST_FIR_DONE, "sequencer step ran past the schedule")
  `PFD_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q) == pfd_pkg::S_DONE, "result appeared outside the final state")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pid_with_filtered_derivative_core.
// Depends on pfd_pkg for widths, register codes and FIR coefficients.
module tb;

  // Request kinds and integral modes as the core decodes them.
  localparam logic REQ_COMPUTE  = 1'b0;
  localparam logic REQ_CLEAR    = 1'b1;
  localparam logic INT_ALWAYS   = 1'b0;
  localparam logic INT_WINDOWED = 1'b1;

  // An index past the last register; the core must ignore writes to it.
  localparam logic [pfd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  localparam int ONE_Q16 = 65536;
  localparam logic signed [pfd_pkg::IO_W-1:0] WORD_TOP = 32'sh7FFF_FFFF;
  localparam logic signed [pfd_pkg::IO_W-1:0] WORD_BOT = 32'sh8000_0000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Comfortably longer than the longest request takes to its result, so that
  // clears and the tail of the run finish before registers are touched.
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    logic                            req_type;
    logic signed [pfd_pkg::IO_W-1:0] setpoint;
    logic signed [pfd_pkg::IO_W-1:0] measurement;
    logic                            integral_mode;
    logic                            fir_enable;
  } pid_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              cfg_we = 1'b0;
  logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [pfd_pkg::CFG_W-1:0]         cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              req_type = REQ_COMPUTE;
  logic signed [pfd_pkg::IO_W-1:0]   setpoint = '0;
  logic signed [pfd_pkg::IO_W-1:0]   measurement = '0;
  logic                              integral_mode = INT_ALWAYS;
  logic                              fir_enable = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [pfd_pkg::IO_W-1:0]   drive;

  pid_with_filtered_derivative_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .setpoint_i     (setpoint),
    .measurement_i  (measurement),
    .integral_mode_i(integral_mode),
    .fir_enable_i   (fir_enable),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .drive_o        (drive)
  );

  always #2 clk = ~clk;

  // Requests waiting for the driver, and drive values still owed by the core.
  pid_req_t                        req_q[$];
  logic signed [pfd_pkg::IO_W-1:0] drive_expect_q[$];
  int                              fail_count = 0;

  // Mirror of the configuration registers, starting from their reset values.
  longint kp_m = 0;
  longint ki_m = 0;
  longint kd_m = 0;
  longint win_m = SAT_HI;
  longint imax_m = SAT_HI;
  longint blend_m = ONE_Q16;
  longint omax_m = SAT_HI;

  // Mirror of the controller state.
  longint last_err_m = 0;
  longint integ_m = 0;
  longint prev_deriv_m = 0;
  longint taps_m [pfd_pkg::FIR_TAPS];

  initial begin
    foreach (taps_m[i]) taps_m[i] = 0;
  end

  function automatic longint sat_word(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Fixed-point product with a Q.16 factor, rounded toward minus infinity.
  // Operands stay well inside 64 bits, so the arithmetic shift is exact.
  function automatic longint q16_mul(input longint v, input longint k);
    return (v * k) >>> 16;
  endfunction

  // Advances the controller mirror by one request. A compute request leaves
  // its drive value on drive_expect_q; a clear only wipes the state.
  function automatic void predict_drive(input pid_req_t r);
    longint err, chg, mag, p_term, i_term, d_term, blend, fir_acc, total;
    if (r.req_type == REQ_CLEAR) begin
      last_err_m = 0;
      integ_m = 0;
      prev_deriv_m = 0;
      foreach (taps_m[i]) taps_m[i] = 0;
      return;
    end
    err = sat_word(longint'(r.setpoint) - longint'(r.measurement));
    chg = sat_word(err - last_err_m);
    mag = (err < 0) ? -err : err;
    // Separation mode only integrates while the error sits inside the window,
    // but the clamp is applied every step so a lowered limit takes effect.
    if (r.integral_mode == INT_ALWAYS || mag <= win_m) integ_m = sat_word(integ_m + err);
    integ_m = clamp_sym(integ_m, imax_m);
    last_err_m = err;

    p_term = sat_word(q16_mul(err, kp_m));
    i_term = sat_word(q16_mul(integ_m, ki_m));
    d_term = sat_word(q16_mul(chg, kd_m));

    // Blend weights above one behave as exactly one.
    blend = (blend_m > ONE_Q16) ? ONE_Q16 : blend_m;
    d_term = sat_word(q16_mul(d_term, blend) + q16_mul(prev_deriv_m, ONE_Q16 - blend));

    // The tap line only moves on requests that use the filter.
    if (r.fir_enable) begin
      for (int i = pfd_pkg::FIR_TAPS - 1; i > 0; i--) taps_m[i] = taps_m[i - 1];
      taps_m[0] = d_term;
      fir_acc = 0;
      for (int i = 0; i < pfd_pkg::FIR_TAPS; i++) begin
        fir_acc += q16_mul(taps_m[i], longint'(pfd_pkg::TAP_GAIN[i]));
      end
      d_term = sat_word(fir_acc);
    end
    prev_deriv_m = d_term;

    total = clamp_sym(p_term + i_term + d_term, omax_m);
    drive_expect_q.push_back(total[pfd_pkg::IO_W-1:0]);
  endfunction

  // Driver: requests go out in bursts separated by random gaps. A gap starts
  // after an accept, so it lands at every point of the core's computation.
  pid_req_t cur_req;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_drive(cur_req);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_valid      <= 1'b1;
          req_type      <= cur_req.req_type;
          setpoint      <= cur_req.setpoint;
          measurement   <= cur_req.measurement;
          integral_mode <= cur_req.integral_mode;
          fir_enable    <= cur_req.fir_enable;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // A zero gap chains two bursts into one long back-to-back stretch.
            burst_left = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(4, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation and
  // runs its own stall pattern of short flickers and longer holds.
  int stall_left = 0;

  always @(posedge clk) begin
    logic signed [pfd_pkg::IO_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (drive_expect_q.size() == 0) begin
          $error("drive: no result expected, got %0d", drive);
          fail_count++;
        end else begin
          want = drive_expect_q.pop_front();
          if (drive !== want) begin
            $error("drive: expected %0d, got %0d", want, drive);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(3, 40);
      end else begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(3, 120);
      end
    end
  end

  // Watchdog against a hung handshake.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Lands one register write at the next rising edge and updates the mirror.
  // The caller drops the write enable after its last write.
  task automatic write_reg(input logic [pfd_pkg::CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[pfd_pkg::CFG_W-1:0];
    case (idx)
      pfd_pkg::CFG_KP_GAIN: kp_m = longint'(data[pfd_pkg::GAIN_W-1:0]);
      pfd_pkg::CFG_KI_GAIN: ki_m = longint'(data[pfd_pkg::GAIN_W-1:0]);
      pfd_pkg::CFG_KD_GAIN: kd_m = longint'(data[pfd_pkg::GAIN_W-1:0]);
      pfd_pkg::CFG_INT_WIN: win_m = longint'(data[pfd_pkg::LIM_W-1:0]);
      pfd_pkg::CFG_INT_MAX: imax_m = longint'(data[pfd_pkg::LIM_W-1:0]);
      pfd_pkg::CFG_BLEND:   blend_m = longint'(data[pfd_pkg::BLEND_W-1:0]);
      pfd_pkg::CFG_OUT_MAX: omax_m = longint'(data[pfd_pkg::LIM_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(input int unsigned kp, ki, kd, win, imax, blend, omax);
    write_reg(pfd_pkg::CFG_KP_GAIN, kp);
    write_reg(pfd_pkg::CFG_KI_GAIN, ki);
    write_reg(pfd_pkg::CFG_KD_GAIN, kd);
    write_reg(pfd_pkg::CFG_INT_WIN, win);
    write_reg(pfd_pkg::CFG_INT_MAX, imax);
    write_reg(pfd_pkg::CFG_BLEND, blend);
    write_reg(pfd_pkg::CFG_OUT_MAX, omax);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_req(input logic kind, input logic signed [pfd_pkg::IO_W-1:0] sp, pv,
                           input logic mode, input logic fir);
    pid_req_t r;
    r.req_type = kind;
    r.setpoint = sp;
    r.measurement = pv;
    r.integral_mode = mode;
    r.fir_enable = fir;
    req_q.push_back(r);
  endtask

  // Mostly a plant that tracks a wandering setpoint, so the integral and the
  // filter see realistic histories; the rest is full-range noise, saturating
  // extremes and the occasional clear.
  task automatic queue_random(input int count);
    pid_req_t r;
    int track_sp, track_pv;
    track_sp = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    track_pv = 0;
    for (int n = 0; n < count; n++) begin
      r.req_type = ($urandom_range(0, 24) == 0) ? REQ_CLEAR : REQ_COMPUTE;
      r.integral_mode = 1'($urandom_range(0, 1));
      r.fir_enable = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0: begin
          r.setpoint = $urandom;
          r.measurement = $urandom;
        end
        1: begin
          r.setpoint = $urandom_range(0, 1) ? WORD_TOP : WORD_BOT;
          r.measurement = $urandom_range(0, 1) ? ~r.setpoint : $urandom;
        end
        default: begin
          if ($urandom_range(0, 15) == 0) track_sp = int'($urandom_range(0, 1 << 22)) - (1 << 21);
          track_pv += (track_sp - track_pv) / 4 + int'($urandom_range(0, 4095)) - 2048;
          r.setpoint = track_sp;
          r.measurement = track_pv;
        end
      endcase
      req_q.push_back(r);
    end
  endtask

  // Waits until the driver has nothing left and every result has arrived,
  // then lets a possible trailing clear finish. The check runs on the falling
  // edge, after the driver's updates of the rising edge have settled.
  task automatic wait_idle();
    while (req_q.size() != 0 || in_valid || drive_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: zero gains, wide limits, full blend.
    queue_random(20);
    wait_idle();

    // Directed part with readable gains: kp 1, ki 0.5, kd 2, window 10,
    // integral limit 100, blend one half, output limit 1000.
    load_config(ONE_Q16, ONE_Q16 / 2, 2 * ONE_Q16, 10 * ONE_Q16, 100 * ONE_Q16,
                ONE_Q16 / 2, 1000 * ONE_Q16);
    queue_req(REQ_COMPUTE, 0, 0, INT_ALWAYS, 1'b0);
    // Error and error change both saturate, in each direction.
    queue_req(REQ_COMPUTE, WORD_TOP, WORD_BOT, INT_ALWAYS, 1'b0);
    queue_req(REQ_COMPUTE, WORD_BOT, WORD_TOP, INT_ALWAYS, 1'b0);
    queue_req(REQ_COMPUTE, WORD_TOP, 0, INT_ALWAYS, 1'b1);
    queue_req(REQ_CLEAR, WORD_TOP, WORD_BOT, INT_WINDOWED, 1'b1);
    // Separation mode inside, outside and exactly on both window edges.
    queue_req(REQ_COMPUTE, 5 * ONE_Q16, 0, INT_WINDOWED, 1'b0);
    queue_req(REQ_COMPUTE, 20 * ONE_Q16, 0, INT_WINDOWED, 1'b0);
    queue_req(REQ_COMPUTE, 10 * ONE_Q16, 0, INT_WINDOWED, 1'b0);
    queue_req(REQ_COMPUTE, 0, 10 * ONE_Q16, INT_WINDOWED, 1'b0);
    queue_req(REQ_COMPUTE, 0, 10 * ONE_Q16 + 1, INT_WINDOWED, 1'b0);
    // Large errors drive the integral into its clamp.
    repeat (3) queue_req(REQ_COMPUTE, 60 * ONE_Q16, 0, INT_ALWAYS, 1'b0);
    // A run through the filter, long enough to fill every tap.
    for (int i = 0; i < 13; i++) begin
      queue_req(REQ_COMPUTE, (i % 3) * 7 * ONE_Q16, -i * ONE_Q16, INT_ALWAYS, 1'b1);
    end
    queue_req(REQ_COMPUTE, 3 * ONE_Q16, 0, INT_ALWAYS, 1'b0);
    queue_req(REQ_CLEAR, 0, 0, INT_ALWAYS, 1'b0);
    queue_req(REQ_COMPUTE, 4 * ONE_Q16, ONE_Q16, INT_ALWAYS, 1'b1);
    // The output limit cuts a huge proportional term.
    queue_req(REQ_COMPUTE, WORD_TOP, 0, INT_ALWAYS, 1'b0);
    wait_idle();

    // Upper extremes: largest gains and limits, blend written above one.
    load_config(32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'(pfd_pkg::LIM_RESET),
                32'(pfd_pkg::LIM_RESET), 32'h1_FFFF, 32'(pfd_pkg::LIM_RESET));
    queue_random(100);
    wait_idle();

    // Lower extremes: no window, no integral room, derivative frozen at blend
    // zero, no output range, then the same with the output opened up.
    load_config($urandom, $urandom, $urandom, 0, 0, 0, 0);
    queue_random(30);
    wait_idle();
    write_reg(pfd_pkg::CFG_OUT_MAX, 32'(pfd_pkg::LIM_RESET));
    cfg_we <= 1'b0;
    queue_random(70);
    wait_idle();

    // Fully random register contents, plus a write the core must ignore.
    repeat (2) begin
      load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      write_reg(CFG_UNUSED_IDX, $urandom);
      cfg_we <= 1'b0;
      queue_random(100);
      wait_idle();
    end

    // Plausible tuning: gains up to four, moderate limits, partial blend.
    load_config($urandom_range(0, 4 * ONE_Q16), $urandom_range(0, ONE_Q16),
                $urandom_range(0, 4 * ONE_Q16), $urandom_range(0, 1 << 22),
                $urandom_range(1 << 20, 1 << 26), $urandom_range(0, ONE_Q16),
                $urandom_range(1 << 20, 1 << 28));
    queue_random(150);
    wait_idle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
